// ----- src/pebd_pkg.sv -----
// ----------------------------------------------------------------------------
// pebd_pkg
// Shared constants and types for the polled encoder and button decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pebd_pkg;

  // time stamp width, differences wrap modulo 2**TIME_BITS
  localparam int unsigned TIME_BITS = 32;

  localparam int unsigned PIN_W      = 8;
  localparam int unsigned RATE_W     = 8;
  localparam int unsigned STALE_W    = 10;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned NUM_BTN    = 4;
  localparam int unsigned NUM_ARM    = 4;
  localparam int unsigned NUM_SLOT   = 6;

  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(10);
  localparam logic [STALE_W-1:0] STALE_RESET = STALE_W'(100);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_LIMIT    = 1'b0,
    CFG_STALE_TIMEOUT = 1'b1
  } cfg_reg_e;

  // result kinds
  localparam logic EV_BUTTON = 1'b0;
  localparam logic EV_WHEEL  = 1'b1;

  // axis codes
  localparam logic AXIS_V = 1'b0;
  localparam logic AXIS_H = 1'b1;

  // wheel step values
  localparam logic signed [1:0] STEP_POS = 2'sb01;
  localparam logic signed [1:0] STEP_NEG = 2'sb11;

  // result slots in tick order: buttons 0..3, then horizontal, then vertical
  localparam logic [2:0] SLOT_H = 3'd4;
  localparam logic [2:0] SLOT_V = 3'd5;

  // pin assignment
  localparam logic [2:0] PIN_H_A = 3'd0;
  localparam logic [2:0] PIN_H_B = 3'd1;
  localparam logic [2:0] PIN_V_A = 3'd3;
  localparam logic [2:0] PIN_V_B = 3'd4;
  localparam logic [2:0] BTN_PIN [NUM_BTN] = '{3'd2, 3'd5, 3'd6, 3'd7};

  // armed direction entries
  localparam logic [1:0] ARM_H_A = 2'd0;
  localparam logic [1:0] ARM_H_B = 2'd1;
  localparam logic [1:0] ARM_V_A = 2'd2;
  localparam logic [1:0] ARM_V_B = 2'd3;

  // working state carried through the four phase samples of one tick
  typedef struct packed {
    logic [NUM_ARM-1:0] armed;
    logic [NUM_ARM-1:0] rearmed;
    logic [1:0]         reported;
    logic [1:0]         neg;
  } enc_st_t;

endpackage

`default_nettype wire

// ----- src/polled_encoder_button_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// polled_encoder_button_decoder_unit
// Four active-low buttons and two gated quadrature encoders, decoded once per
// poll tick into a stream of button and wheel-step events.
// ----------------------------------------------------------------------------
// Path: a tick is taken into the input register, then loads into the event
//   buffer once that is empty or its last event is leaving.
// Throughput: one tick per cycle while it raises no event and none wait; the
//   events of a tick, at most six, leave one per cycle while not stalled.
// Reset: buttons released, directions disarmed, report times zero, rate limit
//   10 ms, stale timeout 100 ms; no clearing pass.
`default_nettype none

module polled_encoder_button_decoder_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // poll tick channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [pebd_pkg::PIN_W-1:0]             pin_levels_i,
  input  logic [pebd_pkg::TIME_BITS-1:0]         now_ms_i,
  // event channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   event_kind_o,
  output logic [1:0]                             item_index_o,
  output logic signed [1:0]                      event_value_o,
  output logic                                   last_of_tick_o,
  // configuration channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pebd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pebd_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import pebd_pkg::*;

  // one phase sample of one encoder
  function automatic enc_st_t sample_phase(
    input enc_st_t            st,
    input logic [PIN_W-1:0]   pins,
    input logic [2:0]         pa,
    input logic [2:0]         pb,
    input logic [1:0]         aa,
    input logic [1:0]         ab,
    input logic               ax,
    input logic               is_b,
    input logic [NUM_ARM-1:0] stale,
    input logic               rate_ok_first,
    input logic               rate_ok_again
  );
    enc_st_t    r;
    logic [2:0] me;
    logic [2:0] other;
    logic [1:0] my_arm;
    logic [1:0] oth_arm;
    logic       both;
    logic       rok;
    r       = st;
    me      = is_b ? pb : pa;
    other   = is_b ? pa : pb;
    my_arm  = is_b ? ab : aa;
    oth_arm = is_b ? aa : ab;
    both    = !pins[pa] && !pins[pb];
    rok     = st.reported[ax] ? rate_ok_again : rate_ok_first;
    if (!pins[me] && rok) begin
      // drop stale arms; an arm set on this tick is never stale
      r.armed = r.armed & ~(stale & ~r.rearmed);
      if (r.armed[oth_arm]) begin
        if (ax == AXIS_V || both) begin
          r.armed[aa] = 1'b0;
          r.armed[ab] = 1'b0;
        end
        if (both) begin
          r.reported[ax] = 1'b1;
          r.neg[ax]      = is_b;
        end
      end else if (pins[other]) begin
        r.armed[my_arm]   = 1'b1;
        r.rearmed[my_arm] = 1'b1;
      end
    end
    return r;
  endfunction

  // configuration registers
  logic [RATE_W-1:0]  rate_q;
  logic [STALE_W-1:0] stale_q;

  // decoder state
  logic [NUM_BTN-1:0]   held_q, held_d;
  logic [NUM_ARM-1:0]   armed_q;
  logic [TIME_BITS-1:0] arm_time_q [NUM_ARM];
  logic [TIME_BITS-1:0] last_rep_q [2];

  // input register
  logic                 s1_valid_q;
  logic [PIN_W-1:0]     s1_pins_q;
  logic [TIME_BITS-1:0] s1_now_q;

  // event buffer: one slot per possible event of a tick
  logic [NUM_SLOT-1:0] mask_q, mask_d;
  logic [NUM_BTN-1:0]  btn_val_q;
  logic [1:0]          neg_q;

  logic                in_take;
  logic                out_take;
  logic                load;
  logic                single;
  logic [NUM_SLOT-1:0] low_bit;
  logic [2:0]          sel;

  logic [NUM_ARM-1:0]  stale;
  logic [1:0]          rate_ok_first;
  logic                rate_ok_again;
  logic [NUM_BTN-1:0]  btn_ev;
  enc_st_t             st0, st1, st2, st3, st4;
  logic [NUM_SLOT-1:0] new_mask;

  // configuration writes, taken at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RATE_RESET;
      stale_q <= STALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_RATE_LIMIT:    rate_q  <= cfg_data_i[RATE_W-1:0];
        CFG_STALE_TIMEOUT: stale_q <= cfg_data_i[STALE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign out_take   = out_valid_o && !out_stall_i;
  assign single     = (mask_q & (mask_q - NUM_SLOT'(1))) == '0;
  assign load       = s1_valid_q && ((mask_q == '0) || (single && out_take));
  assign in_stall_o = s1_valid_q && !load;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_pins_q <= pin_levels_i;
      s1_now_q  <= now_ms_i;
    end
  end

  // time comparisons against the state as it stands before the tick
  always_comb begin
    for (int k = 0; k < NUM_ARM; k++) begin
      stale[k] = (s1_now_q - arm_time_q[k]) > TIME_BITS'(stale_q);
    end
    for (int a = 0; a < 2; a++) begin
      rate_ok_first[a] = (last_rep_q[a] == '0) ||
                         ((s1_now_q - last_rep_q[a]) >= TIME_BITS'(rate_q));
    end
    // after a report on this tick the age is zero
    rate_ok_again = (s1_now_q == '0) || (rate_q == '0);
  end

  // buttons
  always_comb begin
    held_d = held_q;
    for (int b = 0; b < NUM_BTN; b++) begin
      held_d[b] = !s1_pins_q[BTN_PIN[b]];
    end
    btn_ev = held_d ^ held_q;
  end

  // encoder samples in tick order, gated by the updated button state
  always_comb begin
    st0 = '{armed: armed_q, rearmed: '0, reported: '0, neg: '0};
    st1 = st0;
    st2 = st0;
    if (held_d[3]) begin
      st1 = sample_phase(st0, s1_pins_q, PIN_H_A, PIN_H_B, ARM_H_A, ARM_H_B, AXIS_H,
                         1'b0, stale, rate_ok_first[AXIS_H], rate_ok_again);
      st2 = sample_phase(st1, s1_pins_q, PIN_H_A, PIN_H_B, ARM_H_A, ARM_H_B, AXIS_H,
                         1'b1, stale, rate_ok_first[AXIS_H], rate_ok_again);
    end
    st3 = st2;
    st4 = st2;
    if (held_d[2]) begin
      st3 = sample_phase(st2, s1_pins_q, PIN_V_A, PIN_V_B, ARM_V_A, ARM_V_B, AXIS_V,
                         1'b0, stale, rate_ok_first[AXIS_V], rate_ok_again);
      st4 = sample_phase(st3, s1_pins_q, PIN_V_A, PIN_V_B, ARM_V_A, ARM_V_B, AXIS_V,
                         1'b1, stale, rate_ok_first[AXIS_V], rate_ok_again);
    end
    new_mask = {st4.reported[AXIS_V], st4.reported[AXIS_H], btn_ev};
  end

  // state update when the tick moves into the event buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      armed_q    <= '0;
      last_rep_q <= '{default: '0};
    end else if (load) begin
      held_q  <= held_d;
      armed_q <= st4.armed;
      for (int a = 0; a < 2; a++) begin
        if (st4.reported[a]) begin
          last_rep_q[a] <= s1_now_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k < NUM_ARM; k++) begin
        if (st4.rearmed[k]) begin
          arm_time_q[k] <= s1_now_q;
        end
      end
      btn_val_q <= held_d;
      neg_q     <= st4.neg;
    end
  end

  // event buffer drain, lowest slot first
  assign low_bit = mask_q & (~mask_q + NUM_SLOT'(1));

  always_comb begin
    mask_d = mask_q;
    if (load) begin
      mask_d = new_mask;
    end else if (out_take) begin
      mask_d = mask_q & ~low_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_comb begin
    sel = '0;
    for (int s = 0; s < NUM_SLOT; s++) begin
      if (low_bit[s]) begin
        sel = 3'(s);
      end
    end
  end

  // output payload
  assign out_valid_o    = mask_q != '0;
  assign last_of_tick_o = single;

  always_comb begin
    event_kind_o  = EV_BUTTON;
    item_index_o  = sel[1:0];
    event_value_o = {1'b0, btn_val_q[sel[1:0]]};
    if (sel == SLOT_H) begin
      event_kind_o  = EV_WHEEL;
      item_index_o  = {1'b0, AXIS_H};
      event_value_o = neg_q[AXIS_H] ? STEP_NEG : STEP_POS;
    end else if (sel == SLOT_V) begin
      event_kind_o  = EV_WHEEL;
      item_index_o  = {1'b0, AXIS_V};
      event_value_o = neg_q[AXIS_V] ? STEP_NEG : STEP_POS;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb_polled_encoder_button_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_polled_encoder_button_decoder_unit
// Drives poll ticks into the button and encoder decoder and compares every
// event with a behavioral predictor. It covers directed button, encoder,
// rate-limit, stale and time-wrap cases, then randomized quadrature turns
// and noise under several register settings, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_polled_encoder_button_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pebd_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 6;

  localparam logic [1:0] BTN_PRESS   = 2'b01;
  localparam logic [1:0] BTN_RELEASE = 2'b00;

  // pins of buttons 3..0
  localparam logic [3:0][2:0] BUTTON_PINS = {3'd7, 3'd6, 3'd5, 3'd2};

  typedef struct packed {
    logic       kind;
    logic [1:0] index;
    logic [1:0] value;
    logic       last;
  } tick_event_t;

  logic                  clk;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIN_W-1:0]      pin_levels;
  logic [TIME_BITS-1:0]  now_ms;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  event_kind;
  logic [1:0]            item_index;
  logic signed [1:0]     event_value;
  logic                  last_of_tick;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_reg_e              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic               btn_held  [NUM_BTN];
  logic               dir_armed [NUM_ARM];
  logic [31:0]        arm_ms    [NUM_ARM];
  logic [31:0]        report_ms [2];
  logic [RATE_W-1:0]  rate_ms;
  logic [STALE_W-1:0] stale_ms;

  tick_event_t tick_events[$];
  tick_event_t pending_events[$];

  logic [31:0] clock_ms;
  bit          idle_en;
  int          err_count;
  int          stall_left;
  int          quiet_cycles;

  polled_encoder_button_decoder_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pin_levels_i   (pin_levels),
    .now_ms_i       (now_ms),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .event_kind_o   (event_kind),
    .item_index_o   (item_index),
    .event_value_o  (event_value),
    .last_of_tick_o (last_of_tick),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void note_event(input logic kind, input logic [1:0] index,
                                     input logic [1:0] value);
    tick_event_t ev;
    ev.kind  = kind;
    ev.index = index;
    ev.value = value;
    ev.last  = 1'b0;
    tick_events.push_back(ev);
  endfunction

  // one phase sample of one encoder
  function automatic void sample_phase(input logic [7:0] pins, input logic [31:0] now,
                                       input logic vert, input logic is_b);
    logic [2:0]  pa, pb, mine, other;
    logic [1:0]  arm_a, arm_b, my_arm, other_arm;
    logic        axis, both;
    logic [31:0] age;
    int          k;
    pa        = vert ? PIN_V_A : PIN_H_A;
    pb        = vert ? PIN_V_B : PIN_H_B;
    arm_a     = vert ? ARM_V_A : ARM_H_A;
    arm_b     = vert ? ARM_V_B : ARM_H_B;
    axis      = vert ? AXIS_V : AXIS_H;
    mine      = is_b ? pb : pa;
    other     = is_b ? pa : pb;
    my_arm    = is_b ? arm_b : arm_a;
    other_arm = is_b ? arm_a : arm_b;

    // phase high: no effect at all
    if (pins[mine]) return;
    // rate limit, a report time of zero means never reported
    age = now - report_ms[axis];
    if (report_ms[axis] != 32'd0 && age < {24'd0, rate_ms}) return;
    // drop stale directions of both encoders
    for (k = 0; k < NUM_ARM; k++) begin
      age = now - arm_ms[k];
      if (age > {22'd0, stale_ms}) dir_armed[k] = 1'b0;
    end

    if (dir_armed[other_arm]) begin
      both = !pins[pa] && !pins[pb];
      // vertical disarms even without a report
      if (vert || both) begin
        dir_armed[arm_a] = 1'b0;
        dir_armed[arm_b] = 1'b0;
      end
      if (both) begin
        report_ms[axis] = now;
        note_event(EV_WHEEL, {1'b0, axis}, is_b ? STEP_NEG : STEP_POS);
      end
    end else if (pins[other]) begin
      arm_ms[my_arm]    = now;
      dir_armed[my_arm] = 1'b1;
    end
  endfunction

  // all events of one tick, appended to the pending queue
  function automatic void predict_tick(input logic [7:0] pins, input logic [31:0] now);
    tick_event_t ev;
    logic        low;
    int          b;
    tick_events.delete();
    for (b = 0; b < NUM_BTN; b++) begin
      low = !pins[BUTTON_PINS[b]];
      if (!btn_held[b] && low) begin
        btn_held[b] = 1'b1;
        note_event(EV_BUTTON, 2'(b), BTN_PRESS);
      end else if (btn_held[b] && !low) begin
        btn_held[b] = 1'b0;
        note_event(EV_BUTTON, 2'(b), BTN_RELEASE);
      end
    end
    // horizontal gated by button 3, vertical by button 2
    if (btn_held[3]) begin
      sample_phase(pins, now, 1'b0, 1'b0);
      sample_phase(pins, now, 1'b0, 1'b1);
    end
    if (btn_held[2]) begin
      sample_phase(pins, now, 1'b1, 1'b0);
      sample_phase(pins, now, 1'b1, 1'b1);
    end
    if (tick_events.size() != 0) begin
      ev = tick_events.pop_back();
      ev.last = 1'b1;
      tick_events.push_back(ev);
    end
    foreach (tick_events[i]) pending_events.push_back(tick_events[i]);
  endfunction

  function automatic void reset_predictor();
    rate_ms  = RATE_RESET;
    stale_ms = STALE_RESET;
    for (int i = 0; i < NUM_BTN; i++) begin
      btn_held[i]  = 1'b0;
      dir_armed[i] = 1'b0;
      arm_ms[i]    = 32'd0;
    end
    report_ms[0] = 32'd0;
    report_ms[1] = 32'd0;
  endfunction

  // ---------------------------------------------------------------------------
  // event checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_events
    tick_event_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event kind %0d index %0d value %0d last %0d", $time,
                 event_kind, item_index, event_value, last_of_tick);
        err_count++;
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind) begin
          $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, event_kind);
          err_count++;
        end
        if (item_index !== want.index) begin
          $display("%0t: item_index expected %0d actual %0d", $time, want.index,
                   item_index);
          err_count++;
        end
        if (event_value !== want.value) begin
          $display("%0t: event_value expected %0d actual %0d", $time,
                   $signed(want.value), event_value);
          err_count++;
        end
        if (last_of_tick !== want.last) begin
          $display("%0t: last_of_tick expected %0d actual %0d", $time, want.last,
                   last_of_tick);
          err_count++;
        end
      end
    end
  end

  // random stall bursts on the event channel
  always @(posedge clk) begin
    if (stall_left != 0) stall_left--;
    else if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 18);
    if (!idle_en) stall_left = 0;
    out_stall <= (stall_left != 0);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, %0d events outstanding", $time, pending_events.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  task automatic send_tick(input logic [7:0] pins, input logic [31:0] now);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    pin_levels <= pins;
    now_ms     <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tick(pins, now);
  endtask

  // sender pauses until every pending event has come out
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_RATE_LIMIT) rate_ms = data[RATE_W-1:0];
    else stale_ms = data[STALE_W-1:0];
  endtask

  task automatic set_limits(input logic [CFG_DATA_W-1:0] rate_data,
                            input logic [CFG_DATA_W-1:0] stale_data);
    wait_quiet();
    write_reg(CFG_RATE_LIMIT, rate_data);
    write_reg(CFG_STALE_TIMEOUT, stale_data);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] advance_ms();
    case ($urandom_range(0, 19))
      0, 1:    clock_ms = clock_ms;
      2, 3:    clock_ms = clock_ms + $urandom_range(100, 1500);
      4:       clock_ms = $urandom;
      5:       clock_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: clock_ms = clock_ms + $urandom_range(1, 30);
    endcase
    return clock_ms;
  endfunction

  // one gray-code turn of a random encoder, now and then broken up
  task automatic encoder_turn();
    logic       vert, dir;
    logic [7:0] base, pins;
    logic [2:0] pa, pb, first, second;
    vert   = 1'($urandom_range(0, 1));
    dir    = 1'($urandom_range(0, 1));
    pa     = vert ? PIN_V_A : PIN_H_A;
    pb     = vert ? PIN_V_B : PIN_H_B;
    first  = dir ? pb : pa;
    second = dir ? pa : pb;
    base   = 8'($urandom);
    base[vert ? BUTTON_PINS[2] : BUTTON_PINS[3]] = 1'b0;
    base[pa] = 1'b1;
    base[pb] = 1'b1;
    for (int step = 0; step < 4; step++) begin
      pins = base;
      case (step)
        0: pins[first] = 1'b0;
        1: begin
          pins[first]  = 1'b0;
          pins[second] = 1'b0;
        end
        2: pins[second] = 1'b0;
        default: ;
      endcase
      if ($urandom_range(0, 9) == 0) pins = 8'($urandom);
      else if ($urandom_range(0, 7) == 0) pins[$urandom_range(0, 7)] ^= 1'b1;
      send_tick(pins, advance_ms());
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all pins idle, all pins active, release at the top of the time range
  task automatic test_button_edges();
    send_tick(8'hFF, 32'd0);
    send_tick(8'h00, 32'd1);
    send_tick(8'hFF, 32'hFFFF_FFFF);
  endtask

  // horizontal steps both ways, rate-limited sample, phase b without phase a low
  task automatic test_horizontal_steps();
    send_tick(8'h7E, 32'd100);
    send_tick(8'h7C, 32'd110);
    send_tick(8'h7D, 32'd115);
    send_tick(8'h7D, 32'd130);
    send_tick(8'h7C, 32'd140);
    send_tick(8'h7F, 32'd150);
    send_tick(8'h7E, 32'd160);
    send_tick(8'h7D, 32'd170);
    send_tick(8'h7C, 32'd180);
  endtask

  // vertical steps both ways, disarm without a report
  task automatic test_vertical_steps();
    send_tick(8'hB7, 32'd200);
    send_tick(8'hA7, 32'd210);
    send_tick(8'hAF, 32'd230);
    send_tick(8'hA7, 32'd240);
    send_tick(8'hB7, 32'd260);
    send_tick(8'hAF, 32'd270);
    send_tick(8'hA7, 32'd280);
  endtask

  // stale drop, time wrap, report at time zero seen as never reported
  task automatic test_stale_and_wrap();
    send_tick(8'hB7, 32'd300);
    send_tick(8'hA7, 32'd450);
    send_tick(8'h37, 32'hFFFF_FFF8);
    send_tick(8'h27, 32'd0);
    send_tick(8'h2F, 32'd1);
    send_tick(8'h27, 32'd2);
  endtask

  // encoder turns mixed with noise ticks under one register setting
  task automatic test_random_ticks(input int n_items, input logic [9:0] rate_data,
                                   input logic [9:0] stale_data, input bit with_pause);
    int  sent;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    set_limits(rate_data, stale_data);
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        send_tick(8'($urandom), advance_ms());
        sent++;
      end else begin
        encoder_turn();
        sent += 4;
      end
      if (with_pause && !paused && sent >= n_items / 2) begin
        wait_quiet();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    pin_levels = '1;
    now_ms     = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_RATE_LIMIT;
    cfg_data   = '0;
    clock_ms   = 32'd0;
    idle_en    = 1'b1;
    err_count  = 0;
    stall_left = 0;
    quiet_cycles = 0;
    reset_predictor();
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_button_edges();
    test_horizontal_steps();
    test_vertical_steps();
    test_stale_and_wrap();
    test_random_ticks(72, 10'd0, 10'd0, 1'b0);
    test_random_ticks(72, 10'h3FF, 10'h3FF, 1'b1);
    test_random_ticks(72, 10'($urandom_range(0, 40)), 10'($urandom_range(20, 300)), 1'b0);
    // closing stretch without gaps or stalls
    idle_en = 1'b0;
    test_random_ticks(72, 10'($urandom), 10'($urandom), 1'b0);

    wait_quiet();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pebd_pkg.sv
src/polled_encoder_button_decoder_unit.sv
verif/tb_polled_encoder_button_decoder_unit.sv
